/* sv/cbq_pkg.sv */
// ----------------------------------------------------------------------------
// cbq_pkg: shared types and constants of the cascaded biquad filter
// Holds the sequencer states, the fixed-point formats and the per-section
// step numbers of the top level; the multiplier relies on the formats only.
// ----------------------------------------------------------------------------
package cbq_pkg;

  // Coefficients are signed Q3.28.
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;

  // A product rounded to COEF_FRAC fraction bits always fits in this width,
  // whatever the sample width, since the sample fraction is width minus three.
  localparam int PROD_RND_W = COEF_W + 4;

  // Delay words are 48 bits; sums are kept wider and saturated on store.
  localparam int DLY_W = 48;
  localparam int ACC_W = 52;

  // Coefficient slots of one section.
  localparam int SLOT_COUNT = 5;

  // Section sequencer steps (steps 0 to 7 of each section).
  localparam logic [2:0] STP_Z1_RD    = 3'd2;  // delay word z1 address
  localparam logic [2:0] STP_ACC0     = 3'd2;  // b0*x + z0 summed
  localparam logic [2:0] STP_Y        = 3'd3;  // section output formed
  localparam logic [2:0] STP_ACCB     = 3'd4;  // b2*x taken in
  localparam logic [2:0] STP_MUL_Y    = 3'd4;  // first step multiplying y
  localparam logic [2:0] STP_COEF_END = 3'd4;  // last coefficient read
  localparam logic [2:0] STP_A1       = 3'd5;  // a1*y subtracted
  localparam logic [2:0] STP_A2       = 3'd6;  // a2*y subtracted, z0 stored
  localparam logic [2:0] STP_LAST     = 3'd7;  // z1 stored, next section

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } cbq_state_t;

endpackage

/* sv/cbq_mul.sv */
// ----------------------------------------------------------------------------
// cbq_mul: shared coefficient multiplier
// Registers coefficient times operand, then rounds the product to the
// coefficient fraction (half up) on its way out.
// ----------------------------------------------------------------------------
module cbq_mul #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic signed [cbq_pkg::COEF_W-1:0]     coef,
  input  logic signed [SAMPLE_WIDTH-1:0]        opnd,
  output logic signed [cbq_pkg::PROD_RND_W-1:0] prod_rnd
);
  import cbq_pkg::*;

  localparam int PW = COEF_W + SAMPLE_WIDTH;
  localparam int SF = SAMPLE_WIDTH - 3;

  logic signed [PW-1:0] prod;
  logic signed [PW:0]   prod_half;

  always_ff @(posedge clk) begin
    prod <= coef * opnd;
  end

  // Adding half an LSB and dropping the low bits rounds half up.
  assign prod_half = {prod[PW-1], prod} + ((PW + 1)'(1) << (SF - 1));
  assign prod_rnd  = prod_half[PW:SF];

endmodule

/* sv/cascaded_biquad_filter.sv */
// ----------------------------------------------------------------------------
// cascaded_biquad_filter: cascade of second-order IIR sections
// Transposed direct form II biquads sharing one multiplier, with a
// coefficient store loaded through the input stream.
// ----------------------------------------------------------------------------
// A filter beat (tuser mode bit 0) runs the sample through num_sections
// sections in turn, and the block is not ready again until the result is
// in the output register; the one multiplier is used for five products
// per section. A coefficient beat (mode bit 1) with an in-range section
// and slot is written in the cycle it is accepted, and the block is ready
// again in the next cycle. After reset the coefficient store is cleared
// one entry per cycle, every entry, before the first beat is taken. The
// result waits in an output register, so the block may already be working
// on the next sample while it is held.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter #(
  parameter int MAX_SECTIONS = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: num_sections
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // sample, coef_section[2:0], coef_slot[2:0], coef_value[31:0], zero fill
  input  logic [((SAMPLE_WIDTH + 45) / 8) * 8 - 1:0] s_tdata,
  // mode, frame_start
  input  logic [1:0]             s_tuser,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // filtered, zero fill
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,
  // clipped
  output logic [0:0]             m_tuser
);
  import cbq_pkg::*;

  localparam int SW      = SAMPLE_WIDTH;
  localparam int SF      = SW - 3;
  localparam int OUT_DW  = ((SW + 7) / 8) * 8;
  localparam int NCOEF   = SLOT_COUNT * MAX_SECTIONS;
  localparam int NDLY    = 2 * MAX_SECTIONS;
  localparam int CAW     = $clog2(NCOEF);
  localparam int DAW     = $clog2(NDLY);
  localparam int SCW     = $clog2(MAX_SECTIONS + 1);
  localparam int RSH     = COEF_FRAC - SF;
  localparam int RSH_POS = (RSH > 0) ? RSH : 0;
  localparam int LSH     = (RSH < 0) ? ((-RSH) & 7) : 0;
  localparam int HSH     = (RSH_POS > 0) ? RSH_POS - 1 : 0;
  localparam logic [ACC_W:0] HALF = (RSH_POS > 0) ? ((ACC_W + 1)'(1) << HSH) : '0;
  localparam logic signed [ACC_W:0] SMAX = (ACC_W + 1)'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] SMIN = -SMAX - (ACC_W + 1)'(1);
  localparam logic signed [ACC_W-1:0] ZMAX = ACC_W'(48'h7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] ZMIN = -ZMAX - ACC_W'(1);

  // Input fields.
  logic                 in_mode;
  logic                 in_frame;
  logic [SW-1:0]        in_sample;
  logic [2:0]           in_section;
  logic [2:0]           in_slot;
  logic [COEF_W-1:0]    in_coef;

  assign in_mode    = s_tuser[0];
  assign in_frame   = s_tuser[1];
  assign in_sample  = s_tdata[SW-1:0];
  assign in_section = s_tdata[SW+2:SW];
  assign in_slot    = s_tdata[SW+5:SW+3];
  assign in_coef    = s_tdata[SW+37:SW+6];

  cbq_state_t state, state_next;

  logic [3:0]     num_sections;
  logic [SCW-1:0] n_use;
  logic [SCW-1:0] sec_cnt;
  logic [2:0]     step;
  logic [CAW-1:0] coef_base;
  logic [DAW-1:0] dly_base;
  logic [CAW-1:0] clr_addr;
  logic           clr_last;
  logic           in_acc;
  logic           filt_acc;
  logic           out_load;
  logic           sec_last;

  // Coefficient store.
  logic [COEF_W-1:0]        coef_mem [NCOEF];
  logic signed [COEF_W-1:0] coef_q;
  logic                     coef_we;
  logic [CAW-1:0]           coef_wa;
  logic [COEF_W-1:0]        coef_wd;
  logic [8:0]               coef_wa_full;
  logic                     coef_ok;

  // Delay word store.
  logic [DLY_W-1:0] dly_mem [NDLY];
  logic [NDLY-1:0]  dly_vld;
  logic [DLY_W-1:0] dly_q;
  logic             dly_ok;
  logic [DAW-1:0]   dly_ra;
  logic             dly_we;
  logic [DAW-1:0]   dly_wa;
  logic [DLY_W-1:0] dly_wd;

  // Datapath.
  logic signed [SW-1:0]         x;
  logic signed [SW-1:0]         y;
  logic signed [SW-1:0]         opnd;
  logic signed [PROD_RND_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]      prod_ext;
  logic signed [ACC_W-1:0]      z_ext;
  logic signed [ACC_W-1:0]      acc0;
  logic signed [ACC_W-1:0]      acc_a;
  logic signed [ACC_W-1:0]      acc_b;
  logic signed [ACC_W:0]        v_sum;
  logic signed [ACC_W:0]        v_scl;
  logic signed [SW-1:0]         y_new;
  logic                         y_clip;
  logic signed [ACC_W-1:0]      z_src;
  logic                         sat_any;
  logic [SW-1:0]                out_data;
  logic                         out_clip;

  // ---------------------------------------------------------------- control

  assign cfg_ready = 1'b1;
  assign n_use     = (int'(num_sections) > MAX_SECTIONS) ? SCW'(MAX_SECTIONS)
                                                         : SCW'(num_sections);
  assign in_acc    = s_tvalid & s_tready;
  assign filt_acc  = in_acc & ~in_mode;
  assign clr_last  = (clr_addr == CAW'(NCOEF - 1));
  assign sec_last  = (({1'b0, sec_cnt} + (SCW + 1)'(1)) == {1'b0, n_use});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && !in_mode) begin
          state_next = (n_use == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == STP_LAST && sec_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= 4'd1;
      clr_addr     <= '0;
      step         <= '0;
      sec_cnt      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_sections <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CAW'(1);
      end
      if (filt_acc) begin
        step    <= '0;
        sec_cnt <= '0;
      end else if (state == ST_RUN) begin
        step <= step + 3'd1;
        if (step == STP_LAST) begin
          sec_cnt <= sec_cnt + SCW'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (filt_acc) begin
      coef_base <= '0;
      dly_base  <= '0;
    end else if (state == ST_RUN && step == STP_LAST) begin
      coef_base <= coef_base + CAW'(SLOT_COUNT);
      dly_base  <= dly_base + DAW'(2);
    end
  end

  // ------------------------------------------------------- coefficient store

  assign coef_wa_full = 9'(in_section) * 9'(SLOT_COUNT) + 9'(in_slot);
  assign coef_ok      = (int'(in_slot) < SLOT_COUNT) && (int'(in_section) < MAX_SECTIONS);

  always_comb begin
    if (state == ST_CLEAR) begin
      coef_we = 1'b1;
      coef_wa = clr_addr;
      coef_wd = '0;
    end else begin
      coef_we = in_acc && in_mode && coef_ok;
      coef_wa = CAW'(coef_wa_full);
      coef_wd = in_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    if (state == ST_RUN && step <= STP_COEF_END) begin
      coef_q <= coef_mem[coef_base + CAW'(step)];
    end
  end

  // ------------------------------------------------------- delay word store

  // z0 sits at the even address of a section and z1 at the odd one.
  assign dly_ra = (step == STP_Z1_RD) ? (dly_base + DAW'(1)) : dly_base;
  assign dly_we = (state == ST_RUN) && (step == STP_A2 || step == STP_LAST);
  assign dly_wa = (step == STP_LAST) ? (dly_base + DAW'(1)) : dly_base;
  assign z_src  = (step == STP_LAST) ? acc_b : acc_a;

  always_comb begin
    if (z_src > ZMAX) begin
      dly_wd = DLY_W'(ZMAX);
    end else if (z_src < ZMIN) begin
      dly_wd = DLY_W'(ZMIN);
    end else begin
      dly_wd = z_src[DLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_q <= dly_mem[dly_ra];
  end

  // A word with its valid bit clear reads zero; frame-start samples clear all.
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
      dly_ok  <= 1'b0;
    end else begin
      dly_ok <= dly_vld[dly_ra];
      if (filt_acc && in_frame) begin
        dly_vld <= '0;
      end else if (dly_we) begin
        dly_vld[dly_wa] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- datapath

  assign opnd = (step >= STP_MUL_Y) ? y : x;

  cbq_mul #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mul (
    .clk      (clk),
    .coef     (coef_q),
    .opnd     (opnd),
    .prod_rnd (prod_rnd)
  );

  assign prod_ext = {{(ACC_W - PROD_RND_W){prod_rnd[PROD_RND_W-1]}}, prod_rnd};
  assign z_ext    = dly_ok ? {{(ACC_W - DLY_W){dly_q[DLY_W-1]}}, dly_q} : '0;

  // Section output: round to the sample fraction and saturate.
  assign v_sum = {acc0[ACC_W-1], acc0} + HALF;
  assign v_scl = (v_sum >>> RSH_POS) <<< LSH;

  always_comb begin
    y_clip = 1'b0;
    y_new  = v_scl[SW-1:0];
    if (v_scl > SMAX) begin
      y_clip = 1'b1;
      y_new  = SMAX[SW-1:0];
    end else if (v_scl < SMIN) begin
      y_clip = 1'b1;
      y_new  = SMIN[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (filt_acc) begin
      x       <= in_sample;
      sat_any <= 1'b0;
    end else if (state == ST_RUN) begin
      case (step)
        STP_ACC0: begin
          acc0 <= prod_ext + z_ext;
        end
        STP_Y: begin
          y       <= y_new;
          sat_any <= sat_any | y_clip;
          acc_a   <= prod_ext + z_ext;
        end
        STP_ACCB: begin
          acc_b <= prod_ext;
        end
        STP_A1: begin
          acc_a <= acc_a - prod_ext;
        end
        STP_A2: begin
          acc_b <= acc_b - prod_ext;
        end
        STP_LAST: begin
          x <= y;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= x;
      out_clip <= sat_any;
    end
  end

  assign m_tdata    = OUT_DW'(out_data);
  assign m_tuser[0] = out_clip;

`ifndef SYNTHESIS
  a_run_sec_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (sec_cnt < n_use))
    else $error("section counter ran past the sections in use");

  a_busy_after_filter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !in_mode) |=> !s_tready)
    else $error("ready again straight after a filter beat");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("output loaded outside the done state");

  a_no_coef_write_in_run: assert property (@(posedge clk) disable iff (rst)
    coef_we |-> (state != ST_RUN))
    else $error("coefficient store written while filtering");

  a_dly_write_in_run: assert property (@(posedge clk) disable iff (rst)
    dly_we |-> (sec_cnt < n_use))
    else $error("delay word written for an unused section");
`endif

endmodule
